/* rtl/core/bia_pkg.sv */
package bia_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int ADD_W      = DATA_WIDTH + 2;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_NEG = 3'd2;
    localparam logic [2:0] OP_MUL = 3'd3;
    localparam logic [2:0] OP_DIV = 3'd4;
    localparam logic [2:0] OP_GT  = 3'd5;

    typedef struct packed {
        logic [2:0]                   kind;
        logic signed [DATA_WIDTH-1:0] operand_a;
        logic signed [DATA_WIDTH-1:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result;
        logic                         divide_by_zero;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALU,
        S_MUL,
        S_ABSA,
        S_ABSB,
        S_DIV,
        S_FIX,
        S_DONE
    } t_state;

endpackage

/* rtl/core/bitwise_integer_alu_top.sv */
// 32-bit signed integer unit: add, subtract, negate, multiply (low word),
// divide (truncating, divide by zero gives 0 with a flag) and greater-than.
//
// Input channel i_valid/o_ready carries one operation beat (t_in); output
// channel o_valid/i_ready returns one result beat (t_out) per input beat.
// All but a divide by zero pass through one shared adder of DATA_WIDTH+2 bits,
// stepped by a small sequencer; o_ready is high only while it is idle.
//
// Steps from input beat to result register:
//   add, subtract, negate, greater-than: the ALU step
//   multiply: one shift-add step per bit
//   divide: sign removal of both operands, one restoring step per bit,
//   sign fix; a zero divisor goes straight to the result register
// The next input beat is taken only after the previous result is
// registered, so the unit works on one beat at a time.
//
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops
// o_valid. A held result stays in the output register while i_ready is low;
// a new beat may be accepted and worked on meanwhile, and its result waits
// in the sequencer until the output register frees.
module bitwise_integer_alu_top
    import bia_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam int W = DATA_WIDTH;

    t_state r_state, n_state;

    logic [2:0]       r_kind;
    logic [W-1:0]     r_a, r_b, r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg, r_dz;
    t_out             r_out;
    logic             r_out_valid;

    logic [ADD_W-1:0] w_x, w_y, w_sum;
    logic             w_sub;
    logic             w_accept, w_load, w_div_zero;

    assign w_accept   = i_valid && o_ready;
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || i_ready);
    assign w_div_zero = (i_data.kind == OP_DIV) && (i_data.operand_b == '0);

    // shared adder / subtractor
    assign w_sum = w_x + (w_y ^ {ADD_W{w_sub}}) + {{(ADD_W-1){1'b0}}, w_sub};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_data.kind == OP_MUL) begin
                        n_state = S_MUL;
                    end else if (i_data.kind == OP_DIV) begin
                        n_state = w_div_zero ? S_DONE : S_ABSA;
                    end else begin
                        n_state = S_ALU;
                    end
                end
            end
            S_ALU:  n_state = S_DONE;
            S_MUL:  if (r_cnt == '0) n_state = S_DONE;
            S_ABSA: n_state = S_ABSB;
            S_ABSB: n_state = S_DIV;
            S_DIV:  if (r_cnt == '0) n_state = S_FIX;
            S_FIX:  n_state = S_DONE;
            S_DONE: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // adder operand selection
    always_comb begin
        w_x   = '0;
        w_y   = '0;
        w_sub = 1'b0;
        o_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_ALU: begin
                case (r_kind) inside
                    OP_ADD: begin
                        w_x = {2'b00, r_a};
                        w_y = {2'b00, r_b};
                    end
                    OP_SUB: begin
                        w_x   = {2'b00, r_a};
                        w_y   = {2'b00, r_b};
                        w_sub = 1'b1;
                    end
                    OP_NEG: begin
                        w_y   = {2'b00, r_a};
                        w_sub = 1'b1;
                    end
                    OP_GT: begin
                        // b - a on sign-extended operands: negative iff a > b
                        w_x   = {{2{r_b[W-1]}}, r_b};
                        w_y   = {{2{r_a[W-1]}}, r_a};
                        w_sub = 1'b1;
                    end
                    default: begin
                        w_x = '0;
                    end
                endcase
            end
            S_MUL: begin
                w_x = {2'b00, r_acc};
                w_y = {2'b00, r_a};
            end
            S_ABSA, S_FIX: begin
                w_y   = {2'b00, r_a};
                w_sub = 1'b1;
            end
            S_ABSB: begin
                w_y   = {2'b00, r_b};
                w_sub = 1'b1;
            end
            S_DIV: begin
                w_x   = {1'b0, r_acc, r_a[W-1]};
                w_y   = {2'b00, r_b};
                w_sub = 1'b1;
            end
            S_IDLE, S_DONE: begin
                w_sub = 1'b0;
            end
            default: begin
                w_sub = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_kind <= i_data.kind;
                    r_a    <= w_div_zero ? '0 : i_data.operand_a;
                    r_b    <= i_data.operand_b;
                    r_acc  <= '0;
                    r_cnt  <= CNT_W'(W - 1);
                    r_neg  <= i_data.operand_a[W-1] ^ i_data.operand_b[W-1];
                    r_dz   <= w_div_zero;
                end
            end
            S_ALU: begin
                case (r_kind) inside
                    OP_ADD, OP_SUB, OP_NEG: r_a <= w_sum[W-1:0];
                    OP_GT:                  r_a <= {{(W-1){1'b0}}, w_sum[ADD_W-1]};
                    default:                r_a <= '0;
                endcase
            end
            S_MUL: begin
                if (r_b[0]) r_acc <= w_sum[W-1:0];
                r_a   <= {r_a[W-2:0], 1'b0};
                r_b   <= {1'b0, r_b[W-1:1]};
                r_cnt <= r_cnt - 1'b1;
            end
            S_ABSA: if (r_a[W-1]) r_a <= w_sum[W-1:0];
            S_ABSB: if (r_b[W-1]) r_b <= w_sum[W-1:0];
            S_DIV: begin
                // restoring step: keep the difference when there is no borrow
                if (!w_sum[ADD_W-1]) begin
                    r_acc <= w_sum[W-1:0];
                    r_a   <= {r_a[W-2:0], 1'b1};
                end else begin
                    r_acc <= {r_acc[W-2:0], r_a[W-1]};
                    r_a   <= {r_a[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
            end
            S_FIX: if (r_neg) r_a <= w_sum[W-1:0];
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_load) begin
            r_out.result         <= (r_kind == OP_MUL) ? r_acc : r_a;
            r_out.divide_by_zero <= r_dz;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* rtl/core/bia_checker.sv */
module bia_checker
    import bia_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input t_out o_data
);

    // result beat holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result beat dropped or changed under stall");

    // one beat at a time: busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after input beat");

    // divide by zero always reports a zero result
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.divide_by_zero |-> o_data.result == '0)
        else $error("divide by zero with nonzero result");

    // reset clears the output channel
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("output valid or busy after reset");

endmodule

bind bitwise_integer_alu_top bia_checker u_bia_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
